FILE: rtl/core/line_pixel_generator_core_defines.svh
// Assertion macros shared by the line pixel generator checkers.
// Stand-alone header; no other file is needed.
`ifndef LINE_PIXEL_GENERATOR_CORE_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define LPG_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line pixel generator: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset
`define LPG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line pixel generator: next-cycle check failed");

`endif

FILE: rtl/core/lpg_pkg.sv
// Package for the line pixel generator: widths, sequencer states and
// control struct. No dependencies.
package lpg_pkg;

   // Tile coordinate width and fixed field widths on the ports
   localparam int LPG_COORD_BITS    = 5;
   localparam int LPG_FIELD_BITS    = 5;
   localparam int LPG_REQ_DATA_BITS = 24;
   localparam int LPG_RSP_DATA_BITS = 16;

   // Sequencer states
   typedef enum logic {
      WALK_IDLE,
      WALK_EMIT
   } walk_state_type;

   // Kind of segment being walked
   typedef enum logic [1:0] {
      MODE_VERT,
      MODE_HORZ,
      MODE_DIAG
   } line_mode_type;

   // Control from the sequencer to the datapath
   typedef struct packed {
      logic idle;
      logic load;
      logic emit;
      logic step_x;
      logic step_y;
   } walk_ctrl_type;

endpackage

FILE: rtl/core/line_pixel_generator_core.sv
// Line pixel generator core: one segment in, its pixel run out.
// Uses lpg_pkg, lpg_seq and lpg_err_unit.
//
// Takes one segment (start and end point inside a square tile of side
// 2**COORD_BITS, coordinates masked to COORD_BITS) and streams the pixels
// covering it, one result per cycle while rsp_tready is high, the final one marked by rsp_tlast.
// Vertical segments and single points come out in ascending y, horizontal
// segments in ascending x, all others are walked from the start point
// column by column with row steps in between. A segment gives |dx|+|dy|+1
// pixels, at most 63: the block takes the request, then gives one pixel per
// cycle while rsp_tready is high, set by the single error-term adder that
// decides each step. A new request is taken only after the final pixel has
// been accepted.
module line_pixel_generator_core #(
   parameter int COORD_BITS = lpg_pkg::LPG_COORD_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: x_start[4:0], y_start[9:5], x_end[14:10], y_end[19:15], zero
   input  logic [lpg_pkg::LPG_REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // rsp_tdata: pixel_x[4:0], pixel_y[9:5], zero; last_pixel on rsp_tlast
   output logic [lpg_pkg::LPG_RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready
);
   import lpg_pkg::*;

   localparam int ErrBits = COORD_BITS + 2;

   walk_ctrl_type ctrl;

   // Request fields, masked to the tile
   logic [COORD_BITS-1:0] x_start;
   logic [COORD_BITS-1:0] y_start;
   logic [COORD_BITS-1:0] x_end;
   logic [COORD_BITS-1:0] y_end;
   logic                  x_neg;
   logic                  y_neg;

   // Walk registers
   logic [COORD_BITS-1:0]      x_cur_ff, x_cur_in;
   logic [COORD_BITS-1:0]      y_cur_ff, y_cur_in;
   logic [COORD_BITS-1:0]      x_tgt_ff, x_tgt_in;
   logic [COORD_BITS-1:0]      y_tgt_ff, y_tgt_in;
   logic [COORD_BITS-1:0]      dx_ff, dx_in;
   logic [COORD_BITS-1:0]      dy_ff, dy_in;
   logic                       x_neg_ff, x_neg_in;
   logic                       y_neg_ff, y_neg_in;
   line_mode_type              mode_ff, mode_in;
   logic signed [ErrBits-1:0]  err_ff, err_in;

   logic signed [ErrBits-1:0]  err_sum;
   logic                       err_pos;
   logic                       pixel_last;

   assign x_start = req_tdata[0 +: COORD_BITS];
   assign y_start = req_tdata[LPG_FIELD_BITS +: COORD_BITS];
   assign x_end   = req_tdata[2*LPG_FIELD_BITS +: COORD_BITS];
   assign y_end   = req_tdata[3*LPG_FIELD_BITS +: COORD_BITS];
   assign x_neg   = x_end < x_start;
   assign y_neg   = y_end < y_start;

   // Current pixel is the last once both coordinates reach the end point
   assign pixel_last = (x_cur_ff == x_tgt_ff) && (y_cur_ff == y_tgt_ff);

   lpg_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .pixel_last (pixel_last),
      .vertical   (mode_ff == MODE_VERT),
      .err_pos    (err_pos),
      .ctrl       (ctrl)
   );

   lpg_err_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_err (
      .err     (err_ff),
      .delta_x (dx_ff),
      .delta_y (dy_ff),
      .sub_dx  (ctrl.step_y),
      .err_sum (err_sum),
      .err_pos (err_pos)
   );

   // Load a new segment or step the current one
   always_comb begin
      x_cur_in = x_cur_ff;
      y_cur_in = y_cur_ff;
      x_tgt_in = x_tgt_ff;
      y_tgt_in = y_tgt_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      x_neg_in = x_neg_ff;
      y_neg_in = y_neg_ff;
      mode_in  = mode_ff;
      err_in   = err_ff;
      if (ctrl.load) begin
         dx_in  = x_neg ? x_start - x_end : x_end - x_start;
         dy_in  = y_neg ? y_start - y_end : y_end - y_start;
         err_in = '0;
         if (x_start == x_end) begin
            // Vertical or single point: ascending y
            mode_in  = MODE_VERT;
            x_cur_in = x_start;
            x_tgt_in = x_start;
            y_cur_in = y_neg ? y_end : y_start;
            y_tgt_in = y_neg ? y_start : y_end;
            x_neg_in = 1'b0;
            y_neg_in = 1'b0;
         end else if (y_start == y_end) begin
            // Horizontal: ascending x
            mode_in  = MODE_HORZ;
            x_cur_in = x_neg ? x_end : x_start;
            x_tgt_in = x_neg ? x_start : x_end;
            y_cur_in = y_start;
            y_tgt_in = y_start;
            x_neg_in = 1'b0;
            y_neg_in = 1'b0;
         end else begin
            // General: walk from the start point
            mode_in  = MODE_DIAG;
            x_cur_in = x_start;
            x_tgt_in = x_end;
            y_cur_in = y_start;
            y_tgt_in = y_end;
            x_neg_in = x_neg;
            y_neg_in = y_neg;
         end
      end else if (ctrl.step_y) begin
         y_cur_in = y_neg_ff ? y_cur_ff - COORD_BITS'(1) : y_cur_ff + COORD_BITS'(1);
         err_in   = err_sum;
      end else if (ctrl.step_x) begin
         x_cur_in = x_neg_ff ? x_cur_ff - COORD_BITS'(1) : x_cur_ff + COORD_BITS'(1);
         err_in   = err_sum;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      x_cur_ff <= x_cur_in;
      y_cur_ff <= y_cur_in;
      x_tgt_ff <= x_tgt_in;
      y_tgt_ff <= y_tgt_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      x_neg_ff <= x_neg_in;
      y_neg_ff <= y_neg_in;
      mode_ff  <= mode_in;
      err_ff   <= err_in;
   end

   // Drive the channels; take no request while in reset
   assign req_tready = ctrl.idle && !reset;
   assign rsp_tvalid = ctrl.emit;
   assign rsp_tlast  = pixel_last;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[0 +: LPG_FIELD_BITS]              = LPG_FIELD_BITS'(x_cur_ff);
      rsp_tdata[LPG_FIELD_BITS +: LPG_FIELD_BITS] = LPG_FIELD_BITS'(y_cur_ff);
   end

endmodule

FILE: rtl/core/lpg_err_unit.sv
// Shared error-term adder of the line walker: adds |dy| on a column step,
// subtracts |dx| on a row step, and flags a positive error. Uses lpg_pkg.
module lpg_err_unit #(
   parameter int COORD_BITS = lpg_pkg::LPG_COORD_BITS
) (
   input  logic signed [COORD_BITS+1:0] err,
   input  logic        [COORD_BITS-1:0] delta_x,
   input  logic        [COORD_BITS-1:0] delta_y,
   input  logic                         sub_dx,
   output logic signed [COORD_BITS+1:0] err_sum,
   output logic                         err_pos
);
   import lpg_pkg::*;

   logic signed [COORD_BITS+1:0] dx_ext;
   logic signed [COORD_BITS+1:0] dy_ext;
   logic signed [COORD_BITS+1:0] operand;

   // Select the operand and add
   always_comb begin
      dx_ext  = signed'({2'b00, delta_x});
      dy_ext  = signed'({2'b00, delta_y});
      operand = sub_dx ? -dx_ext : dy_ext;
      err_sum = err + operand;
   end

   // Error above zero means the row lags the exact line: take a row step
   assign err_pos = !err[COORD_BITS+1] && (|err);

endmodule

FILE: rtl/core/lpg_seq.sv
// Sequencer of the line pixel generator: takes a request when idle, then
// steps one pixel per accepted result until the end point. Uses lpg_pkg.
module lpg_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   rsp_tready,
   input  logic                   pixel_last,
   input  logic                   vertical,
   input  logic                   err_pos,
   output lpg_pkg::walk_ctrl_type ctrl
);
   import lpg_pkg::*;

   walk_state_type state_ff;
   walk_state_type state_in;
   logic           advance;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         WALK_IDLE: begin
            if (req_tvalid) state_in = WALK_EMIT;
         end
         WALK_EMIT: begin
            if (rsp_tready && pixel_last) state_in = WALK_IDLE;
         end
         default: state_in = WALK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WALK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs: advance to the next pixel once the current one is taken
   always_comb begin
      ctrl    = '0;
      advance = 1'b0;
      unique case (state_ff)
         WALK_IDLE: begin
            ctrl.idle = 1'b1;
            ctrl.load = req_tvalid;
         end
         WALK_EMIT: begin
            ctrl.emit   = 1'b1;
            advance     = rsp_tready && !pixel_last;
            ctrl.step_y = advance && (vertical || err_pos);
            ctrl.step_x = advance && !(vertical || err_pos);
         end
         default: ctrl = '0;
      endcase
   end

endmodule

FILE: rtl/core/lpg_checker.sv
// Port-level checker for the line pixel generator core, bound to the top.
// Uses lpg_pkg and line_pixel_generator_core_defines.svh.
`include "line_pixel_generator_core_defines.svh"

module lpg_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [lpg_pkg::LPG_RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                                  rsp_tlast,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready
);
   import lpg_pkg::*;

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Never take a request while a pixel is still on offer
   `LPG_ASSERT_SAME(a_no_req_while_busy, clock, reset, req_fire, !rsp_tvalid)

   // A taken request shows its first pixel in the next cycle
   `LPG_ASSERT_NEXT(a_first_pixel, clock, reset, req_fire, rsp_tvalid && !req_tready)

   // After the final pixel is taken the block is ready again
   `LPG_ASSERT_NEXT(a_ready_after_last, clock, reset, rsp_fire && rsp_tlast,
                    req_tready && !rsp_tvalid)

   // A stalled pixel holds
   `LPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind line_pixel_generator_core lpg_checker u_lpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
